// File: sv/video_scanline_timing_generator_assert.svh
// assertion macros used by the checker file
`ifndef VIDEO_SCANLINE_TIMING_GENERATOR_ASSERT_SVH
`define VIDEO_SCANLINE_TIMING_GENERATOR_ASSERT_SVH

// checked outside reset
`define VSTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vstg assertion failed");

// checked during reset as well
`define VSTG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vstg reset assertion failed");

`endif

// File: sv/vstg_pkg.sv
`timescale 1ns / 1ps
package vstg_pkg;

  localparam int LINE_W     = 10;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 32;
  localparam int CYC_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int FRAC_BITS  = 40;

  localparam longint unsigned DEF_CPU_CLOCK_HZ   = 64'd200000000;
  localparam longint unsigned DEF_PIXEL_CLOCK_HZ = 64'd27000000;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_LEN_M1 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LINES_M1    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_MODE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_IRQ   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_IRQ  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_VB_START    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_VB_END      = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RENDER_DLY  = 3'd7;

  // video mode bits
  localparam int MODE_VGA_BIT   = 0;
  localparam int MODE_INTLC_BIT = 1;

  // reset values
  localparam logic [LINE_W-1:0] RST_LINE_LEN_M1 = 10'd857;
  localparam logic [LINE_W-1:0] RST_LINES_M1    = 10'd262;
  localparam logic [MODE_W-1:0] RST_VIDEO_MODE  = 2'd0;
  localparam logic [LINE_W-1:0] RST_FIRST_IRQ   = 10'd260;
  localparam logic [LINE_W-1:0] RST_SECOND_IRQ  = 10'd336;
  localparam logic [LINE_W-1:0] RST_VB_START    = 10'd260;
  localparam logic [LINE_W-1:0] RST_VB_END      = 10'd336;
  localparam logic [CNT_W-1:0]  RST_RENDER_DLY  = 32'd0;
  localparam logic [LINE_W-1:0] RST_LINE        = 10'd1023;

  typedef struct packed {
    logic [CNT_W-1:0]  line_len;
    logic [LINE_W-1:0] lines_m1;
    logic [LINE_W-1:0] first_irq;
    logic [LINE_W-1:0] second_irq;
    logic [LINE_W-1:0] vb_start;
    logic [LINE_W-1:0] vb_end;
    logic              interlaced;
    logic [CNT_W-1:0]  render_delay;
  } cfg_t;

  // packed msb first: current_line at bit 0
  typedef struct packed {
    logic [CNT_W-1:0]  frame_count;
    logic              render_done;
    logic              line_zero_irq;
    logic              second_line_irq;
    logic              first_line_irq;
    logic              field_bit;
    logic              in_vertical_blank;
    logic [LINE_W-1:0] current_line;
  } res_t;

endpackage

// File: sv/vstg_cfg.sv
`timescale 1ns / 1ps
module vstg_cfg #(
  parameter longint unsigned CPU_CLOCK_HZ   = vstg_pkg::DEF_CPU_CLOCK_HZ,
  parameter longint unsigned PIXEL_CLOCK_HZ = vstg_pkg::DEF_PIXEL_CLOCK_HZ
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vstg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vstg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output vstg_pkg::cfg_t                      cfg
);
  import vstg_pkg::*;

  localparam int PROD_W = FRAC_BITS + LINE_W + 1;

  // line len = n * cpu / pix (pix/2 unless VGA), whole + rounded-up fraction
  localparam longint unsigned PIX_FULL  = PIXEL_CLOCK_HZ;
  localparam longint unsigned PIX_HALF  = PIXEL_CLOCK_HZ / 2;
  localparam longint unsigned INT_FULL  = CPU_CLOCK_HZ / PIX_FULL;
  localparam longint unsigned REM_FULL  = CPU_CLOCK_HZ % PIX_FULL;
  localparam longint unsigned INT_HALF  = CPU_CLOCK_HZ / PIX_HALF;
  localparam longint unsigned REM_HALF  = CPU_CLOCK_HZ % PIX_HALF;
  localparam logic [79:0] FRAC_FULL =
    ((80'(REM_FULL) << FRAC_BITS) + 80'(PIX_FULL) - 80'd1) / 80'(PIX_FULL);
  localparam logic [79:0] FRAC_HALF =
    ((80'(REM_HALF) << FRAC_BITS) + 80'(PIX_HALF) - 80'd1) / 80'(PIX_HALF);

  logic [LINE_W-1:0] ll_m1_r, lines_m1_r, first_r, second_r, vbs_r, vbe_r;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  delay_r, len_r, len_nxt;
  logic [LINE_W-1:0] ll_sel;
  logic [MODE_W-1:0] mode_sel;

  function automatic logic [CNT_W-1:0] calc_len(input logic [LINE_W-1:0] m1,
                                                input logic [MODE_W-1:0] mode);
    logic [LINE_W:0]   n;
    logic [CNT_W-1:0]  whole;
    logic [PROD_W-1:0] frac;
    logic [CNT_W-1:0]  len;
    n = {1'b0, m1} + {{LINE_W{1'b0}}, 1'b1};
    if (mode[MODE_VGA_BIT]) begin
      whole = CNT_W'(64'(n) * INT_FULL);
      frac  = PROD_W'(n) * PROD_W'(FRAC_FULL[FRAC_BITS-1:0]);
    end else begin
      whole = CNT_W'(64'(n) * INT_HALF);
      frac  = PROD_W'(n) * PROD_W'(FRAC_HALF[FRAC_BITS-1:0]);
    end
    len = whole + CNT_W'(frac >> FRAC_BITS);
    if (mode[MODE_INTLC_BIT]) len = len >> 1;
    return len;
  endfunction

  always_comb begin
    ll_sel   = (cfg_we && cfg_addr == REG_LINE_LEN_M1) ? cfg_wdata[LINE_W-1:0] : ll_m1_r;
    mode_sel = (cfg_we && cfg_addr == REG_VIDEO_MODE) ? cfg_wdata[MODE_W-1:0] : mode_r;
    len_nxt  = calc_len(ll_sel, mode_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_m1_r    <= RST_LINE_LEN_M1;
      lines_m1_r <= RST_LINES_M1;
      mode_r     <= RST_VIDEO_MODE;
      first_r    <= RST_FIRST_IRQ;
      second_r   <= RST_SECOND_IRQ;
      vbs_r      <= RST_VB_START;
      vbe_r      <= RST_VB_END;
      delay_r    <= RST_RENDER_DLY;
      len_r      <= calc_len(RST_LINE_LEN_M1, RST_VIDEO_MODE);
    end else begin
      len_r <= len_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_LINE_LEN_M1: ll_m1_r    <= cfg_wdata[LINE_W-1:0];
          REG_LINES_M1:    lines_m1_r <= cfg_wdata[LINE_W-1:0];
          REG_VIDEO_MODE:  mode_r     <= cfg_wdata[MODE_W-1:0];
          REG_FIRST_IRQ:   first_r    <= cfg_wdata[LINE_W-1:0];
          REG_SECOND_IRQ:  second_r   <= cfg_wdata[LINE_W-1:0];
          REG_VB_START:    vbs_r      <= cfg_wdata[LINE_W-1:0];
          REG_VB_END:      vbe_r      <= cfg_wdata[LINE_W-1:0];
          REG_RENDER_DLY:  delay_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.line_len     = len_r;
  assign cfg.lines_m1     = lines_m1_r;
  assign cfg.first_irq    = first_r;
  assign cfg.second_irq   = second_r;
  assign cfg.vb_start     = vbs_r;
  assign cfg.vb_end       = vbe_r;
  assign cfg.interlaced   = mode_r[MODE_INTLC_BIT];
  assign cfg.render_delay = delay_r;

endmodule

// File: sv/vstg_core.sv
`timescale 1ns / 1ps
module vstg_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vstg_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [vstg_pkg::CYC_W-1:0]     in_cycles,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vstg_pkg::res_t                 out_res
);
  import vstg_pkg::*;

  logic [CNT_W-1:0]  acc_r, acc_nxt, frames_r, frames_nxt, cnt_r, cnt_nxt;
  logic [LINE_W-1:0] line_r, line_nxt, line_adv;
  logic              blank_r, blank_nxt, field_r, field_nxt, armed_r, armed_nxt;
  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic [CNT_W-1:0]  acc_sum, cyc32;
  logic              take, run, adv, done;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    cyc32    = {{(CNT_W-CYC_W){1'b0}}, in_cycles};
    run      = !in_action && (cfg.line_len != '0);
    acc_sum  = acc_r + cyc32;
    adv      = run && (acc_sum > cfg.line_len);
    line_adv = (line_r >= cfg.lines_m1) ? '0 : line_r + 1'b1;

    acc_nxt    = acc_r;
    line_nxt   = line_r;
    blank_nxt  = blank_r;
    field_nxt  = field_r;
    frames_nxt = frames_r;
    armed_nxt  = armed_r;
    cnt_nxt    = cnt_r;
    done       = 1'b0;

    if (in_action) begin
      armed_nxt = 1'b1;
      cnt_nxt   = cfg.render_delay;
    end else if (run) begin
      acc_nxt = adv ? acc_sum - cfg.line_len : acc_sum;
      if (armed_r) begin
        if (cnt_r < cyc32) begin
          armed_nxt = 1'b0;
          done      = 1'b1;
        end
        cnt_nxt = cnt_r - cyc32;
      end
    end

    if (adv) begin
      line_nxt = line_adv;
      // end line wins when both match
      if (line_adv == cfg.vb_end)        blank_nxt = 1'b0;
      else if (line_adv == cfg.vb_start) blank_nxt = 1'b1;
      field_nxt = cfg.interlaced ? ~field_r : 1'b0;
      if (line_adv == '0) frames_nxt = frames_r + 1'b1;
    end

    res_nxt.current_line      = line_nxt;
    res_nxt.in_vertical_blank = blank_nxt;
    res_nxt.field_bit         = field_nxt;
    res_nxt.first_line_irq    = adv && (line_adv == cfg.first_irq);
    res_nxt.second_line_irq   = adv && (line_adv == cfg.second_irq);
    res_nxt.line_zero_irq     = adv && (line_adv == '0);
    res_nxt.render_done       = done;
    res_nxt.frame_count       = frames_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      line_r      <= RST_LINE;
      blank_r     <= 1'b0;
      field_r     <= 1'b0;
      frames_r    <= '0;
      armed_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r    <= acc_nxt;
        line_r   <= line_nxt;
        blank_r  <= blank_nxt;
        field_r  <= field_nxt;
        frames_r <= frames_nxt;
        armed_r  <= armed_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (take) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: sv/video_scanline_timing_generator.sv
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_tvalid/in_tready  tdata: elapsed_cycles; tuser: action
// out      out  out_tvalid/out_tready tdata: line, vblank, field, irqs, done, frames
// cfg      in   cfg_we               cfg_addr index, cfg_wdata value
//
// one item per cycle while out_tready takes each result, one result per item,
// result appears the cycle after its input transaction; the line/blank/frame
// state update is one add, compare and subtract into state and result registers
// line length in cpu cycles is recomputed into a register on length/mode writes
// in_tready stays high while the output register is empty or being taken
// synchronous active-low reset restores register defaults and the line counter
// to 1023, so the first line advance wraps to line zero
module video_scanline_timing_generator #(
  parameter longint unsigned CPU_CLOCK_HZ   = vstg_pkg::DEF_CPU_CLOCK_HZ,
  parameter longint unsigned PIXEL_CLOCK_HZ = vstg_pkg::DEF_PIXEL_CLOCK_HZ
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [vstg_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] elapsed_cycles
  input  logic                                in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] current_line, [10] in_vertical_blank, [11] field_bit, [12] first_line_irq,
  // [13] second_line_irq, [14] line_zero_irq, [15] render_done, [47:16] frame_count
  output logic [vstg_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [vstg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vstg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vstg_pkg::*;

  cfg_t cfg;
  res_t res;

  vstg_cfg #(
    .CPU_CLOCK_HZ  (CPU_CLOCK_HZ),
    .PIXEL_CLOCK_HZ(PIXEL_CLOCK_HZ)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  vstg_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_cycles(in_tdata[CYC_W-1:0]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = res;

endmodule

// File: sv/vstg_checker.sv
`timescale 1ns / 1ps
`include "video_scanline_timing_generator_assert.svh"
module vstg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [vstg_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import vstg_pkg::*;

  // stalled result holds
  `VSTG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // every input transaction yields a result next cycle
  `VSTG_ASSERT(a_in_to_out, in_tvalid && in_tready |=> out_tvalid)
  // start render carries no pulses
  `VSTG_ASSERT(a_render_quiet, in_tvalid && in_tready && in_tuser |=> out_tdata[15:12] == 4'd0)
  // line-zero pulse only on line zero
  `VSTG_ASSERT(a_zero_line, out_tvalid && out_tdata[14] |-> out_tdata[9:0] == 10'd0)
  // no result right after reset
  `VSTG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind video_scanline_timing_generator vstg_checker u_vstg_checker (.*);
